// ===== hw/rtl/ncae_pkg.sv =====
// ---------------------------------------------------------------------------
// ncae_pkg
// Shared types and constants of the nibble RAM/ALU execute block.
// ---------------------------------------------------------------------------
package ncae_pkg;

    localparam int RAM_WORDS_DEF = 128;
    localparam int MASK_W        = 7;
    localparam int CMD_W         = 5;
    localparam int IN_TDATA_W    = 24;
    localparam int OUT_TDATA_W   = 16;

    localparam logic [MASK_W-1:0] MASK_RESET  = 7'h7f;
    localparam logic [3:0]        ADX_NO_SKIP = 4'd10;

    typedef enum logic [CMD_W-1:0] {
        CMD_LB    = 5'd0,
        CMD_LBL   = 5'd1,
        CMD_EXBLA = 5'd2,
        CMD_INCB  = 5'd3,
        CMD_DECB  = 5'd4,
        CMD_EXC   = 5'd5,
        CMD_EXCI  = 5'd6,
        CMD_EXCD  = 5'd7,
        CMD_LDA   = 5'd8,
        CMD_LAX   = 5'd9,
        CMD_ADD   = 5'd10,
        CMD_ADD11 = 5'd11,
        CMD_ADX   = 5'd12,
        CMD_COMA  = 5'd13,
        CMD_ROT   = 5'd14,
        CMD_RC    = 5'd15,
        CMD_SC    = 5'd16,
        CMD_TC    = 5'd17,
        CMD_TAM   = 5'd18,
        CMD_TMI   = 5'd19,
        CMD_TA0   = 5'd20,
        CMD_TABL  = 5'd21,
        CMD_RM    = 5'd22,
        CMD_SM    = 5'd23
    } t_cmd;

    // architectural registers
    typedef struct packed {
        logic [3:0] acc;
        logic       carry;
        logic [3:0] low;
        logic [2:0] bank;
        logic       last_lax;
    } t_state;

    // RAM write request from the ALU
    typedef struct packed {
        logic       we;
        logic [3:0] data;
    } t_ram_wr;

    // one result item
    typedef struct packed {
        logic [2:0] bank;
        logic [3:0] low;
        logic       carry;
        logic [3:0] acc;
        logic       skip;
    } t_result;

endpackage

// ===== hw/rtl/ncae_ram.sv =====
// ---------------------------------------------------------------------------
// ncae_ram
// Nibble data RAM with per-entry valid bits (reads zero until written),
// registered read and same-cycle write forwarding.
// ---------------------------------------------------------------------------
module ncae_ram #(
    parameter int RAM_WORDS = ncae_pkg::RAM_WORDS_DEF,
    localparam int AW = $clog2(RAM_WORDS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [3:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [3:0]    o_rdata
);

    logic [3:0]           mem [RAM_WORDS];
    logic [RAM_WORDS-1:0] r_vld;
    logic [3:0]           r_q;
    logic                 r_q_vld;
    logic                 r_fwd;
    logic [3:0]           r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_q        <= mem[i_raddr];
        r_fwd_data <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_q_vld <= r_vld[i_raddr];
            r_fwd   <= i_we && (i_waddr == i_raddr);
        end
    end

    assign o_rdata = r_fwd ? r_fwd_data : (r_q_vld ? r_q : 4'd0);

endmodule

// ===== hw/rtl/ncae_alu.sv =====
// ---------------------------------------------------------------------------
// ncae_alu
// Combinational execute of one data instruction: next register state,
// skip flag and RAM write request.
// ---------------------------------------------------------------------------
module ncae_alu (
    input  ncae_pkg::t_state  i_state,
    input  logic [4:0]        i_cmd,
    input  logic [3:0]        i_op,
    input  logic [7:0]        i_sb,
    input  logic [6:0]        i_mask,
    input  logic [3:0]        i_ram,
    output ncae_pkg::t_state  o_state,
    output ncae_pkg::t_ram_wr o_wr,
    output logic              o_skip
);

    logic [4:0] sum_add;
    logic [4:0] sum_adc;
    logic [4:0] sum_adx;
    logic [3:0] low_inc;
    logic [3:0] low_dec;
    logic [2:0] bank_xor;
    logic [3:0] bit_sel;
    logic [6:0] sb_masked;

    always_comb begin
        sum_add   = {1'b0, i_state.acc} + {1'b0, i_ram};
        sum_adc   = sum_add + {4'd0, i_state.carry};
        sum_adx   = {1'b0, i_state.acc} + {1'b0, i_op};
        low_inc   = i_state.low + 4'd1;
        low_dec   = i_state.low - 4'd1;
        bank_xor  = i_state.bank ^ {1'b0, i_op[1:0]};
        bit_sel   = 4'd1 << i_op[1:0];
        sb_masked = i_sb[6:0] & i_mask;

        o_state          = i_state;
        o_state.last_lax = (ncae_pkg::t_cmd'(i_cmd) == ncae_pkg::CMD_LAX);
        o_wr.we          = 1'b0;
        o_wr.data        = i_state.acc;
        o_skip           = 1'b0;

        unique case (ncae_pkg::t_cmd'(i_cmd))
            ncae_pkg::CMD_LB: begin
                o_state.bank = {i_state.bank[2], i_op[1:0]};
                o_state.low  = {{2{|i_op[3:2]}}, i_op[3:2]};
            end
            ncae_pkg::CMD_LBL: begin
                o_state.low  = i_sb[3:0];
                o_state.bank = sb_masked[6:4];
            end
            ncae_pkg::CMD_EXBLA: begin
                o_state.acc = i_state.low;
                o_state.low = i_state.acc;
            end
            ncae_pkg::CMD_INCB: begin
                o_state.low = low_inc;
                o_skip      = (low_inc == 4'd0);
            end
            ncae_pkg::CMD_DECB: begin
                o_state.low = low_dec;
                o_skip      = (low_dec == 4'hf);
            end
            ncae_pkg::CMD_EXC: begin
                o_state.acc  = i_ram;
                o_state.bank = bank_xor;
                o_wr.we      = 1'b1;
            end
            ncae_pkg::CMD_EXCI: begin
                o_state.acc  = i_ram;
                o_state.bank = bank_xor;
                o_wr.we      = 1'b1;
                o_state.low  = low_inc;
                o_skip       = (low_inc == 4'd0);
            end
            ncae_pkg::CMD_EXCD: begin
                o_state.acc  = i_ram;
                o_state.bank = bank_xor;
                o_wr.we      = 1'b1;
                o_state.low  = low_dec;
                o_skip       = (low_dec == 4'hf);
            end
            ncae_pkg::CMD_LDA: begin
                o_state.acc  = i_ram;
                o_state.bank = bank_xor;
            end
            ncae_pkg::CMD_LAX: begin
                // a run of LAX only loads on its first
                if (!i_state.last_lax) begin
                    o_state.acc = i_op;
                end
            end
            ncae_pkg::CMD_ADD: begin
                o_state.acc = sum_add[3:0];
            end
            ncae_pkg::CMD_ADD11: begin
                o_state.acc   = sum_adc[3:0];
                o_state.carry = sum_adc[4];
                o_skip        = sum_adc[4];
            end
            ncae_pkg::CMD_ADX: begin
                o_state.acc = sum_adx[3:0];
                o_skip      = sum_adx[4] && (i_op != ncae_pkg::ADX_NO_SKIP);
            end
            ncae_pkg::CMD_COMA: begin
                o_state.acc = ~i_state.acc;
            end
            ncae_pkg::CMD_ROT: begin
                o_state.acc   = {i_state.carry, i_state.acc[3:1]};
                o_state.carry = i_state.acc[0];
            end
            ncae_pkg::CMD_RC: begin
                o_state.carry = 1'b0;
            end
            ncae_pkg::CMD_SC: begin
                o_state.carry = 1'b1;
            end
            ncae_pkg::CMD_TC: begin
                o_skip = !i_state.carry;
            end
            ncae_pkg::CMD_TAM: begin
                o_skip = (i_state.acc == i_ram);
            end
            ncae_pkg::CMD_TMI: begin
                o_skip = |(i_ram & bit_sel);
            end
            ncae_pkg::CMD_TA0: begin
                o_skip = (i_state.acc == 4'd0);
            end
            ncae_pkg::CMD_TABL: begin
                o_skip = (i_state.acc == i_state.low);
            end
            ncae_pkg::CMD_RM: begin
                o_wr.we   = 1'b1;
                o_wr.data = i_ram & ~bit_sel;
            end
            ncae_pkg::CMD_SM: begin
                o_wr.we   = 1'b1;
                o_wr.data = i_ram | bit_sel;
            end
            default: begin
                // unused codes: no operation
            end
        endcase
    end

endmodule

// ===== hw/rtl/nibble_cpu_ram_alu_execute.sv =====
// ---------------------------------------------------------------------------
// nibble_cpu_ram_alu_execute
// Data-instruction execute unit of a 4-bit controller: accumulator, carry,
// banked RAM pointer and nibble data RAM, one result per instruction.
// ---------------------------------------------------------------------------
//  channel   direction  ports            contents
//  s_axis    in         tvalid/tready    tdata: command, opcode_low, second_byte
//  m_axis    out        tvalid/tready    tdata: skip, acc, carry, ptr low, bank
//  cfg       in         valid/ready      data: ram_address_mask (always ready)
//
//  One instruction per cycle when not stalled: input register -> execute -> result register.
//  The RAM read for the next instruction is issued at the next-pointer
//  address, so the registered read data is ready when the instruction runs.
//  Reset clears state, valid flags and RAM valid bits at once, mask all ones; no sweep.
//  A stalled result only holds the pipe when the input register is also full.
// ---------------------------------------------------------------------------
module nibble_cpu_ram_alu_execute #(
    parameter int RAM_WORDS = ncae_pkg::RAM_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [4:0] command, [8:5] opcode_low, [16:9] second_byte, [23:17] zero
    input  logic [ncae_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] skip_next, [4:1] accumulator_out, [5] carry_out,
    // [9:6] pointer_low_out, [12:10] pointer_bank_out, [15:13] zero
    output logic [ncae_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);

    localparam int AW = $clog2(RAM_WORDS);

    logic              r_in_vld;
    logic [4:0]        r_cmd;
    logic [3:0]        r_op;
    logic [7:0]        r_sb;
    ncae_pkg::t_state  r_st;
    ncae_pkg::t_state  n_st;
    ncae_pkg::t_state  w_alu_st;
    logic [6:0]        r_mask;
    logic [6:0]        n_mask;
    logic              r_out_vld;
    ncae_pkg::t_result r_out;

    logic              w_exec;
    logic              w_in_take;
    logic              w_skip;
    ncae_pkg::t_ram_wr w_wr;
    logic [3:0]        w_rdata;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;

    // pointer & mask, folded into the RAM size by taking off four, two and
    // one times its size (the masked pointer is below eight times the size)
    function automatic logic [AW-1:0] ram_addr(input logic [2:0] bank,
                                               input logic [3:0] low,
                                               input logic [6:0] mask);
        logic [9:0] a;
        a = {3'b000, ({bank, low} & mask)};
        for (int s = 2; s >= 0; s--) begin
            if (a >= (10'(RAM_WORDS) << s)) begin
                a = a - (10'(RAM_WORDS) << s);
            end
        end
        return a[AW-1:0];
    endfunction

    assign w_exec        = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_exec;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    ncae_alu u_alu (
        .i_state (r_st),
        .i_cmd   (r_cmd),
        .i_op    (r_op),
        .i_sb    (r_sb),
        .i_mask  (r_mask),
        .i_ram   (w_rdata),
        .o_state (w_alu_st),
        .o_wr    (w_wr),
        .o_skip  (w_skip)
    );

    always_comb begin
        n_st    = w_exec ? w_alu_st : r_st;
        n_mask  = i_cfg_valid ? i_cfg_data : r_mask;
        w_waddr = ram_addr(r_st.bank, r_st.low, r_mask);
        w_raddr = ram_addr(n_st.bank, n_st.low, n_mask);
    end

    ncae_ram #(
        .RAM_WORDS (RAM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_exec && w_wr.we),
        .i_waddr (w_waddr),
        .i_wdata (w_wr.data),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_cmd <= s_axis_tdata[4:0];
            r_op  <= s_axis_tdata[8:5];
            r_sb  <= s_axis_tdata[16:9];
        end
        if (w_exec) begin
            r_out.skip  <= w_skip;
            r_out.acc   <= w_alu_st.acc;
            r_out.carry <= w_alu_st.carry;
            r_out.low   <= w_alu_st.low;
            r_out.bank  <= w_alu_st.bank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_st      <= '0;
            r_mask    <= ncae_pkg::MASK_RESET;
        end else begin
            r_in_vld  <= w_in_take || (r_in_vld && !w_exec);
            r_out_vld <= w_exec || (r_out_vld && !m_axis_tready);
            r_st      <= n_st;
            r_mask    <= n_mask;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'd0, r_out};

    // an executed instruction always lands in the result register
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && w_exec |=> r_out_vld)
        else $error("executed instruction produced no result");

    // registers only move when an instruction executes
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !w_exec |=> $stable(r_st))
        else $error("state changed without execute");

    // a write to the address being read is seen by the next instruction
    a_ram_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && w_exec && w_wr.we && (w_waddr == w_raddr)
        |=> w_rdata == $past(w_wr.data))
        else $error("RAM write not forwarded");

    // only test, carry-out add and pointer step instructions may request a skip
    a_skip_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && w_exec && w_skip |->
        (r_cmd == ncae_pkg::CMD_INCB || r_cmd == ncae_pkg::CMD_DECB ||
         r_cmd == ncae_pkg::CMD_EXCI || r_cmd == ncae_pkg::CMD_EXCD ||
         r_cmd == ncae_pkg::CMD_ADD11 || r_cmd == ncae_pkg::CMD_ADX ||
         r_cmd == ncae_pkg::CMD_TC || r_cmd == ncae_pkg::CMD_TAM ||
         r_cmd == ncae_pkg::CMD_TMI || r_cmd == ncae_pkg::CMD_TA0 ||
         r_cmd == ncae_pkg::CMD_TABL))
        else $error("skip from a non-test instruction");

    // repeated LAX leaves the accumulator alone
    a_lax_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && w_exec && (r_cmd == ncae_pkg::CMD_LAX) && r_st.last_lax
        |=> r_st.acc == $past(r_st.acc))
        else $error("repeated LAX loaded the accumulator");

endmodule
